>>> rtl/jddm_pkg.sv
package jddm_pkg;

    localparam int SAMPLE_W = 10;
    localparam int DUTY_W   = 8;
    localparam int AX_W     = DUTY_W + 1;
    localparam int TRIG_W   = 32;
    localparam int CROSS_W  = TRIG_W + AX_W + 1;
    localparam int NUM_ANG  = 16;
    localparam int NUM_WIN  = 12;
    localparam int NUM_TERM = 14;

    localparam logic [DUTY_W-1:0] DEAD_ZONE_RST = DUTY_W'(50);
    localparam longint FIX_ONE = longint'(1) << 30;

    // series divisors (2k)(2k+1) and (2k-1)(2k) for k = 1..14
    localparam longint SIN_DIV [NUM_TERM] = '{
        6, 20, 42, 72, 110, 156, 210, 272, 342, 420, 506, 600, 702, 812
    };
    localparam longint COS_DIV [NUM_TERM] = '{
        2, 12, 30, 56, 90, 132, 182, 240, 306, 380, 462, 552, 650, 756
    };

    typedef enum logic [3:0] {
        RGN_DEAD  = 4'd0,
        RGN_DIAG1 = 4'd1,
        RGN_DIAG2 = 4'd2,
        RGN_DIAG3 = 4'd3,
        RGN_DIAG4 = 4'd4,
        RGN_OCT1  = 4'd5,
        RGN_OCT2  = 4'd6,
        RGN_OCT3  = 4'd7,
        RGN_OCT4  = 4'd8,
        RGN_OCT5  = 4'd9,
        RGN_OCT6  = 4'd10,
        RGN_OCT7  = 4'd11,
        RGN_OCT8  = 4'd12,
        RGN_HOLD  = 4'd13
    } region_t;

    // angle limits in hundredths of a radian
    localparam int ANG_P70  = 0;
    localparam int ANG_P87  = 1;
    localparam int ANG_P223 = 2;
    localparam int ANG_P247 = 3;
    localparam int ANG_N240 = 4;
    localparam int ANG_N230 = 5;
    localparam int ANG_N90  = 6;
    localparam int ANG_N60  = 7;
    localparam int ANG_P79  = 8;
    localparam int ANG_P157 = 9;
    localparam int ANG_P236 = 10;
    localparam int ANG_P314 = 11;
    localparam int ANG_N314 = 12;
    localparam int ANG_N236 = 13;
    localparam int ANG_N157 = 14;
    localparam int ANG_N79  = 15;

    localparam int ANG_HUND [NUM_ANG] = '{
        70, 87, 223, 247, -240, -230, -90, -60,
        79, 157, 236, 314, -314, -236, -157, -79
    };

    // window hit bits, diagonals first
    localparam int WIN_DIAG1 = 0;
    localparam int WIN_DIAG2 = 1;
    localparam int WIN_DIAG3 = 2;
    localparam int WIN_DIAG4 = 3;
    localparam int WIN_OCT1  = 4;
    localparam int WIN_OCT2  = 5;
    localparam int WIN_OCT3  = 6;
    localparam int WIN_OCT4  = 7;
    localparam int WIN_OCT5  = 8;
    localparam int WIN_OCT6  = 9;
    localparam int WIN_OCT7  = 10;
    localparam int WIN_OCT8  = 11;

    typedef struct packed {
        logic [DUTY_W-1:0]  ah;
        logic [DUTY_W-1:0]  av;
        logic [DUTY_W-1:0]  rem;
        logic               dead;
        logic [NUM_WIN-1:0] hit;
    } eval_t;

    // sine or cosine of hund/100 rad, 30 fraction bits, via the half angle
    function automatic longint trig_fix(input int hund, input bit want_cos);
        int     m;
        int     k;
        longint a;
        longint ts;
        longint ss;
        longint tc;
        longint sc;
        longint sn;
        longint cs;
        m  = (hund < 0) ? -hund : hund;
        a  = (longint'(m) * FIX_ONE + 100) / 200;
        ts = a;
        ss = a;
        tc = FIX_ONE;
        sc = FIX_ONE;
        for (k = 1; k <= NUM_TERM; k++) begin
            ts = ts * a / FIX_ONE;
            ts = ts * a / FIX_ONE;
            ts = ts / SIN_DIV[k-1];
            tc = tc * a / FIX_ONE;
            tc = tc * a / FIX_ONE;
            tc = tc / COS_DIV[k-1];
            if ((k % 2) == 1) begin
                ss = ss - ts;
                sc = sc - tc;
            end else begin
                ss = ss + ts;
                sc = sc + tc;
            end
        end
        sn = 2 * ss * sc / FIX_ONE;
        cs = (sc * sc - ss * ss) / FIX_ONE;
        if (hund < 0) begin
            sn = -sn;
        end
        return want_cos ? cs : sn;
    endfunction

endpackage

>>> rtl/joystick_differential_drive_mixer_core.sv
// Joystick mixer for a differential drive. Each transaction on the s_ side
// carries one 10-bit axis sample (tuser 0 vertical, 1 horizontal); the block
// stores it, centers both stored axes to -255..255 and returns one result
// transaction with both motor duties, direction bits and the matched region
// (dead zone, diagonal, octant, or hold of the previous outputs). The angle
// windows are decided by exact cross products against fixed sine/cosine
// constants. Results pass a compare stage, then an output register, and
// the block takes one sample per cycle while m_tready stays high. The dead
// zone register sits at APB addresses 0 to 3 (paddr[2] low) and resets to 50.
module joystick_differential_drive_mixer_core
    import jddm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sample[9:0]
    input  logic        s_tuser,   // kind

    output logic        m_tvalid,
    input  logic        m_tready,
    // left_duty[7:0], right_duty[15:8], left_forward[16], right_forward[17],
    // region[21:18]
    output logic [23:0] m_tdata
);

    logic [DUTY_W-1:0]   dead_zone_reg;
    logic [SAMPLE_W-1:0] vert_raw_reg, vert_raw_next;
    logic [SAMPLE_W-1:0] horiz_raw_reg, horiz_raw_next;
    logic                p1_valid_reg;
    eval_t               p1_reg, p1_next;
    logic                out_valid_reg;
    logic [DUTY_W-1:0]   left_duty_reg, left_duty_next;
    logic [DUTY_W-1:0]   right_duty_reg, right_duty_next;
    logic                left_fwd_reg, left_fwd_next;
    logic                right_fwd_reg, right_fwd_next;
    region_t             region_reg, region_next;

    logic ready_out, accept, move1, cfg_wr;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {24'd0, dead_zone_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dead_zone_reg <= DEAD_ZONE_RST;
        end else if (cfg_wr) begin
            dead_zone_reg <= pwdata[DUTY_W-1:0];
        end
    end

    // handshakes
    assign ready_out = !out_valid_reg || m_tready;
    assign s_tready  = !p1_valid_reg || ready_out;
    assign accept    = s_tvalid && s_tready;
    assign move1     = p1_valid_reg && ready_out;
    assign m_tvalid  = out_valid_reg;

    // stored axes
    assign vert_raw_next  = (!s_tuser) ? s_tdata[SAMPLE_W-1:0] : vert_raw_reg;
    assign horiz_raw_next = s_tuser ? s_tdata[SAMPLE_W-1:0] : horiz_raw_reg;

    // centering: trunc((2*s - 1023) / 4)
    logic signed [SAMPLE_W:0] hd, vd;
    logic [SAMPLE_W-1:0]      hmag, vmag;
    logic [DUTY_W-1:0]        ah, av;
    logic signed [AX_W-1:0]   hc, vc;
    logic                     upper, lower;

    always_comb begin
        hd   = $signed({horiz_raw_next, 1'b0}) - (SAMPLE_W+1)'(1023);
        vd   = $signed({vert_raw_next, 1'b0}) - (SAMPLE_W+1)'(1023);
        hmag = hd[SAMPLE_W] ? SAMPLE_W'(-hd) : hd[SAMPLE_W-1:0];
        vmag = vd[SAMPLE_W] ? SAMPLE_W'(-vd) : vd[SAMPLE_W-1:0];
        ah   = hmag[SAMPLE_W-1:2];
        av   = vmag[SAMPLE_W-1:2];
        hc   = hd[SAMPLE_W] ? -$signed({1'b0, ah}) : $signed({1'b0, ah});
        vc   = vd[SAMPLE_W] ? -$signed({1'b0, av}) : $signed({1'b0, av});
        upper = (vc > 0) || ((vc == 0) && (hc < 0));
        lower = (vc < 0);
    end

    // angle comparisons against each limit
    logic [NUM_ANG-1:0] ang_gt, ang_lt;

    for (genvar i = 0; i < NUM_ANG; i++) begin : g_ang
        localparam logic signed [TRIG_W-1:0] SIN_C =
            TRIG_W'(trig_fix(ANG_HUND[i], 1'b0));
        localparam logic signed [TRIG_W-1:0] COS_C =
            TRIG_W'(trig_fix(ANG_HUND[i], 1'b1));
        logic signed [CROSS_W-1:0] cross_prod;
        logic                      pos, neg;

        assign cross_prod = CROSS_W'(COS_C) * CROSS_W'(vc) - CROSS_W'(SIN_C) * CROSS_W'(hc);
        assign neg   = cross_prod[CROSS_W-1];
        assign pos   = !neg && (cross_prod != '0);

        if (ANG_HUND[i] > 0) begin : g_pos
            assign ang_gt[i] = upper && pos;
            assign ang_lt[i] = !upper || neg;
        end else begin : g_neg
            assign ang_gt[i] = !lower || pos;
            assign ang_lt[i] = lower && neg;
        end
    end

    always_comb begin
        p1_next.ah   = ah;
        p1_next.av   = av;
        p1_next.rem  = (ah >= av) ? (ah - av) : (av - ah);
        p1_next.dead = (ah < dead_zone_reg) && (av < dead_zone_reg);
        p1_next.hit[WIN_DIAG1] = ang_gt[ANG_P70]  && ang_lt[ANG_P87];
        p1_next.hit[WIN_DIAG2] = ang_gt[ANG_P223] && ang_lt[ANG_P247];
        p1_next.hit[WIN_DIAG3] = ang_gt[ANG_N240] && ang_lt[ANG_N230];
        p1_next.hit[WIN_DIAG4] = ang_gt[ANG_N90]  && ang_lt[ANG_N60];
        p1_next.hit[WIN_OCT1]  = upper            && ang_lt[ANG_P79];
        p1_next.hit[WIN_OCT2]  = ang_gt[ANG_P79]  && ang_lt[ANG_P157];
        p1_next.hit[WIN_OCT3]  = ang_gt[ANG_P157] && ang_lt[ANG_P236];
        p1_next.hit[WIN_OCT4]  = ang_gt[ANG_P236] && ang_lt[ANG_P314];
        p1_next.hit[WIN_OCT5]  = ang_gt[ANG_N314] && !ang_gt[ANG_N236];
        p1_next.hit[WIN_OCT6]  = ang_gt[ANG_N236] && ang_lt[ANG_N157];
        p1_next.hit[WIN_OCT7]  = ang_gt[ANG_N157] && ang_lt[ANG_N79];
        p1_next.hit[WIN_OCT8]  = ang_gt[ANG_N79]  && lower;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vert_raw_reg  <= '0;
            horiz_raw_reg <= '0;
            p1_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                vert_raw_reg  <= vert_raw_next;
                horiz_raw_reg <= horiz_raw_next;
            end
            if (s_tready) begin
                p1_valid_reg <= accept;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            p1_reg <= p1_next;
        end
    end

    // window selection; the output register doubles as the held state
    always_comb begin
        left_duty_next  = left_duty_reg;
        right_duty_next = right_duty_reg;
        left_fwd_next   = left_fwd_reg;
        right_fwd_next  = right_fwd_reg;
        region_next     = RGN_HOLD;
        priority if (p1_reg.dead) begin
            left_duty_next  = '0;
            right_duty_next = '0;
            left_fwd_next   = 1'b0;
            right_fwd_next  = 1'b0;
            region_next     = RGN_DEAD;
        end else if (p1_reg.hit[WIN_DIAG1]) begin
            right_duty_next = '0;
            right_fwd_next  = 1'b0;
            left_duty_next  = p1_reg.ah;
            region_next     = RGN_DIAG1;
        end else if (p1_reg.hit[WIN_DIAG2]) begin
            left_duty_next  = '0;
            left_fwd_next   = 1'b0;
            right_duty_next = p1_reg.ah;
            region_next     = RGN_DIAG2;
        end else if (p1_reg.hit[WIN_DIAG3]) begin
            right_duty_next = '0;
            left_fwd_next   = 1'b0;
            left_duty_next  = p1_reg.ah;
            region_next     = RGN_DIAG3;
        end else if (p1_reg.hit[WIN_DIAG4]) begin
            left_duty_next  = '0;
            right_fwd_next  = 1'b0;
            right_duty_next = p1_reg.ah;
            region_next     = RGN_DIAG4;
        end else if (p1_reg.hit[WIN_OCT1]) begin
            left_duty_next  = p1_reg.ah;
            left_fwd_next   = 1'b1;
            right_duty_next = p1_reg.rem;
            right_fwd_next  = 1'b0;
            region_next     = RGN_OCT1;
        end else if (p1_reg.hit[WIN_OCT2]) begin
            left_duty_next  = p1_reg.av;
            left_fwd_next   = 1'b1;
            right_duty_next = p1_reg.rem;
            right_fwd_next  = 1'b1;
            region_next     = RGN_OCT2;
        end else if (p1_reg.hit[WIN_OCT3]) begin
            left_duty_next  = p1_reg.rem;
            left_fwd_next   = 1'b1;
            right_duty_next = p1_reg.av;
            right_fwd_next  = 1'b1;
            region_next     = RGN_OCT3;
        end else if (p1_reg.hit[WIN_OCT4]) begin
            left_duty_next  = p1_reg.rem;
            left_fwd_next   = 1'b0;
            right_duty_next = p1_reg.ah;
            right_fwd_next  = 1'b1;
            region_next     = RGN_OCT4;
        end else if (p1_reg.hit[WIN_OCT5]) begin
            left_duty_next  = p1_reg.ah;
            left_fwd_next   = 1'b0;
            right_duty_next = p1_reg.rem;
            right_fwd_next  = 1'b1;
            region_next     = RGN_OCT5;
        end else if (p1_reg.hit[WIN_OCT6]) begin
            left_duty_next  = p1_reg.av;
            left_fwd_next   = 1'b0;
            right_duty_next = p1_reg.rem;
            right_fwd_next  = 1'b0;
            region_next     = RGN_OCT6;
        end else if (p1_reg.hit[WIN_OCT7]) begin
            left_duty_next  = p1_reg.rem;
            left_fwd_next   = 1'b0;
            right_duty_next = p1_reg.av;
            right_fwd_next  = 1'b0;
            region_next     = RGN_OCT7;
        end else if (p1_reg.hit[WIN_OCT8]) begin
            left_duty_next  = p1_reg.rem;
            left_fwd_next   = 1'b1;
            right_duty_next = p1_reg.ah;
            right_fwd_next  = 1'b0;
            region_next     = RGN_OCT8;
        end else begin
            region_next     = RGN_HOLD;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            left_duty_reg  <= '0;
            right_duty_reg <= '0;
            left_fwd_reg   <= 1'b0;
            right_fwd_reg  <= 1'b0;
            region_reg     <= RGN_DEAD;
        end else begin
            if (ready_out) begin
                out_valid_reg <= move1;
            end
            if (move1) begin
                left_duty_reg  <= left_duty_next;
                right_duty_reg <= right_duty_next;
                left_fwd_reg   <= left_fwd_next;
                right_fwd_reg  <= right_fwd_next;
                region_reg     <= region_next;
            end
        end
    end

    assign m_tdata = {2'b00, region_reg, right_fwd_reg, left_fwd_reg,
                      right_duty_reg, left_duty_reg};

    // dead zone result stops both motors
    a_dead_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (region_reg == RGN_DEAD)) |->
        ((left_duty_reg == '0) && (right_duty_reg == '0) && !left_fwd_reg && !right_fwd_reg))
        else $error("dead zone result with motor drive");

    // a held result repeats the previous outputs
    a_hold_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (move1 && !p1_reg.dead && (p1_reg.hit == '0)) |=>
        ($stable(left_duty_reg) && $stable(right_duty_reg) &&
         $stable(left_fwd_reg) && $stable(right_fwd_reg) && (region_reg == RGN_HOLD)))
        else $error("held result changed outputs");

    // an empty output stage never blocks the input
    a_no_false_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // stage one only advances into a free output register
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(m_tdata) && m_tvalid))
        else $error("pending result overwritten");

endmodule
